FILE: hw/rtl/pmsa_pkg.sv
// Shared constants for the packed matrix scatter-accumulate unit.
// Field widths, storage sizing, register indexes and internal operation codes.
// No dependencies.
package pmsa_pkg;

	// Storage sizing
	localparam int MAX_ORDER   = 64;
	localparam int STORE_DEPTH = 8192;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	// Signed width for address arithmetic: holds STORE_DEPTH and a sign bit
	localparam int CALC_W      = (ADDR_W + 2 > 18) ? ADDR_W + 2 : 18;

	// Item field widths
	localparam int IDX_W      = 7;
	localparam int CONTRIB_W  = 32;
	localparam int RADDR_W    = 13;
	localparam int DATA_W     = 48;

	// Configuration register widths
	localparam int FMT_W      = 2;
	localparam int ORDER_W    = 7;
	localparam int BW_W       = 7;
	localparam int KL_W       = 6;
	localparam int CUT_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd4;

	// Storage formats
	localparam logic [FMT_W-1:0] FMT_SYM_PACKED = 2'd0;
	localparam logic [FMT_W-1:0] FMT_SYM_BANDED = 2'd1;
	localparam logic [FMT_W-1:0] FMT_GEN_BANDED = 2'd2;
	localparam logic [FMT_W-1:0] FMT_FULL       = 2'd3;

	// Request types
	localparam logic REQ_ACC  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Register reset values
	localparam logic [FMT_W-1:0]   FMT_RESET    = FMT_FULL;
	localparam logic [ORDER_W-1:0] ORDER_RESET  = 7'd64;
	localparam logic [BW_W-1:0]    BW_RESET     = 7'd1;
	localparam logic [KL_W-1:0]    KL_RESET     = 6'd0;
	localparam logic [CUT_W-1:0]   CUTOFF_RESET = 7'd64;

	// Operation resolved in stage one
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_SKIP = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_ACC  = 2'd2;
	localparam logic [OP_W-1:0] OP_OOS  = 2'd3;

	// Accumulator limits and comparison constants
	localparam logic [DATA_W-1:0] ACC_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] ACC_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [CALC_W-1:0] MAX_ORDER_C   = CALC_W'(MAX_ORDER);
	localparam logic signed [CALC_W-1:0] STORE_DEPTH_C = CALC_W'(STORE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

endpackage

FILE: hw/rtl/pmsa_if.sv
// Handshake channels of the packed matrix scatter-accumulate unit:
// request, result and configuration write. Depends on pmsa_pkg.
interface pmsa_req_if;
	import pmsa_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic signed [IDX_W-1:0]     row_index;
	logic signed [IDX_W-1:0]     col_index;
	logic signed [CONTRIB_W-1:0] contribution;
	logic                        row_sign_negative;
	logic                        col_sign_negative;
	logic [RADDR_W-1:0]          read_address;
	modport source (output valid, req_type, row_index, col_index, contribution,
		row_sign_negative, col_sign_negative, read_address, input ready);
	modport sink (input valid, req_type, row_index, col_index, contribution,
		row_sign_negative, col_sign_negative, read_address, output ready);
endinterface

interface pmsa_rsp_if;
	import pmsa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_data;
	logic                     accumulated;
	logic                     saturated;
	logic                     out_of_store;
	modport source (output valid, read_data, accumulated, saturated, out_of_store,
		input ready);
	modport sink (input valid, read_data, accumulated, saturated, out_of_store,
		output ready);
endinterface

interface pmsa_cfg_if;
	import pmsa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/pmsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pmsa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/packed_matrix_scatter_accumulate_unit.sv
// Packed matrix scatter-accumulate unit: top level.
// Depends on pmsa_pkg, the channel interfaces in pmsa_if and pmsa_ram.
//
// Usage
//   cfg : register writes (format, order, band width, sub-diagonals, cutoff);
//         always ready; write only while no item is in flight.
//   req : one item per handshake, either an accumulate (row, column, Q16.16
//         value, two sign bits) or a read of one stored 48-bit word.
//   rsp : exactly one result item per request item, in request order.
// Timing
//   The store is one single-port-read RAM; an item reads its word in stage one
//   and writes the saturated sum back in stage two. A result passes from stage
//   two into the output register, and the next request is taken the cycle its
//   predecessor leaves stage two; no request is taken while an item sits in
//   stage one, as the RAM read-modify-write turn needs both stages.
// Reset
//   After arst_n rises the store is swept to zero, one word a cycle over all
//   STORE_DEPTH (8192) words; req.ready stays low throughout.
// Back-pressure
//   While rsp is stalled the result is held; one further item may be taken
//   and waits in stage two with its RAM word until the output register frees.
module packed_matrix_scatter_accumulate_unit (
	input logic        clk,
	input logic        arst_n,
	pmsa_cfg_if.sink   cfg,
	pmsa_req_if.sink   req,
	pmsa_rsp_if.source rsp
);
	import pmsa_pkg::*;

	// Clearing sweep
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Configuration
	logic [FMT_W-1:0]   fmt_q;
	logic [ORDER_W-1:0] order_q;
	logic [BW_W-1:0]    bw_q;
	logic [KL_W-1:0]    kl_q;
	logic [CUT_W-1:0]   cutoff_q;

	// Stage one: accepted item
	logic                        v_s1;
	logic                        type_s1;
	logic signed [IDX_W-1:0]     i_s1;
	logic signed [IDX_W-1:0]     j_s1;
	logic signed [CONTRIB_W-1:0] contrib_s1;
	logic                        neg_s1;
	logic [RADDR_W-1:0]          raddr_s1;

	// Stage two: RAM word arrives
	logic                 v_s2;
	logic [OP_W-1:0]      op_s2;
	logic [ADDR_W-1:0]    addr_s2;
	logic [CONTRIB_W:0]   val_s2;

	// Output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_acc_q;
	logic              out_sat_q;
	logic              out_oos_q;

	// Stage one logic
	logic [IDX_W-1:0]         i_u;
	logic [IDX_W-1:0]         j_u;
	logic signed [CALC_W-1:0] i_c;
	logic signed [CALC_W-1:0] j_c;
	logic signed [CALC_W-1:0] n_c;
	logic signed [CALC_W-1:0] bw_c;
	logic signed [CALC_W-1:0] kl_c;
	logic signed [CALC_W-1:0] mult_c;
	logic signed [CALC_W-1:0] offs_c;
	logic signed [CALC_W-1:0] prod_c;
	logic signed [CALC_W-1:0] addr_c;
	logic                     skip_c;
	logic                     oos_c;
	logic [OP_W-1:0]          op_c;
	logic [CONTRIB_W:0]       ext_c;
	logic [CONTRIB_W:0]       val_c;

	// Stage two logic
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W:0]   sum_c;
	logic              sat_c;
	logic [DATA_W-1:0] clip_c;
	logic [DATA_W-1:0] res_data_c;
	logic              res_acc_c;
	logic              res_oos_c;
	logic              s2_fire;

	// RAM ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;

	assign cfg.ready = 1'b1;
	assign s2_fire   = v_s2 && (!out_valid_q || rsp.ready);
	assign req.ready = !clearing_q && !v_s1 && (!v_s2 || s2_fire);

	// Address mapping, skip decision, operation and signed contribution
	always_comb begin
		i_u    = $unsigned(i_s1);
		j_u    = $unsigned(j_s1);
		i_c    = $signed(CALC_W'(i_u));
		j_c    = $signed(CALC_W'(j_u));
		n_c    = $signed(CALC_W'(order_q));
		bw_c   = $signed(CALC_W'(bw_q));
		kl_c   = $signed(CALC_W'(kl_q));
		mult_c = n_c;
		offs_c = i_c;
		case (fmt_q)
			FMT_SYM_PACKED: begin
				mult_c = (n_c <<< 1) - j_c - CALC_W'(1);
				offs_c = i_c;
			end
			FMT_SYM_BANDED: begin
				mult_c = bw_c;
				offs_c = i_c - j_c;
			end
			FMT_GEN_BANDED: begin
				mult_c = (kl_c <<< 1) + bw_c;
				offs_c = kl_c + bw_c - CALC_W'(1) + i_c - j_c;
			end
			default: begin
				mult_c = n_c;
				offs_c = i_c;
			end
		endcase
		prod_c = j_c * mult_c;
		// packed triangle: the product is always even
		if (fmt_q == FMT_SYM_PACKED) begin
			addr_c = (prod_c >>> 1) + offs_c;
		end else begin
			addr_c = prod_c + offs_c;
		end
		if (type_s1 == REQ_READ) begin
			addr_c = $signed(CALC_W'(raddr_s1));
		end
		oos_c = addr_c[CALC_W-1] || (addr_c >= STORE_DEPTH_C);

		skip_c = i_s1[IDX_W-1] || j_s1[IDX_W-1] || (i_u >= cutoff_q) || (j_u >= cutoff_q)
			|| (i_c >= MAX_ORDER_C) || (j_c >= MAX_ORDER_C);
		// symmetric formats keep the lower triangle only
		if ((fmt_q == FMT_SYM_PACKED || fmt_q == FMT_SYM_BANDED) && (j_c > i_c)) begin
			skip_c = 1'b1;
		end

		if (type_s1 == REQ_READ) begin
			op_c = oos_c ? OP_OOS : OP_READ;
		end else if (skip_c) begin
			op_c = OP_SKIP;
		end else begin
			op_c = oos_c ? OP_OOS : OP_ACC;
		end

		ext_c = {contrib_s1[CONTRIB_W-1], contrib_s1};
		val_c = neg_s1 ? (~ext_c + 1'b1) : ext_c;
	end

	// Add, clip and form the result
	always_comb begin
		sum_c  = {ram_rdata[DATA_W-1], ram_rdata}
			+ {{(DATA_W-CONTRIB_W){val_s2[CONTRIB_W]}}, val_s2};
		sat_c  = sum_c[DATA_W] != sum_c[DATA_W-1];
		clip_c = sat_c ? (sum_c[DATA_W] ? ACC_MIN : ACC_MAX) : sum_c[DATA_W-1:0];
		res_data_c = '0;
		res_acc_c  = 1'b0;
		res_oos_c  = 1'b0;
		unique case (op_s2)
			OP_READ: res_data_c = ram_rdata;
			OP_ACC: begin
				res_data_c = clip_c;
				res_acc_c  = 1'b1;
			end
			OP_OOS:  res_oos_c = 1'b1;
			default: res_data_c = '0;
		endcase
	end

	// Sweep writes zero; otherwise write back the clipped sum as the item leaves
	always_comb begin
		ram_we    = clearing_q || (s2_fire && op_s2 == OP_ACC);
		ram_waddr = clearing_q ? clr_addr_q : addr_s2;
		ram_wdata = clearing_q ? '0 : clip_c;
	end

	pmsa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (v_s1),
		.raddr (addr_c[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			fmt_q       <= FMT_RESET;
			order_q     <= ORDER_RESET;
			bw_q        <= BW_RESET;
			kl_q        <= KL_RESET;
			cutoff_q    <= CUTOFF_RESET;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end

			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_FORMAT: fmt_q <= cfg.data[FMT_W-1:0];
					CFG_ORDER: begin
						// clamp the order to the largest supported matrix
						if (CALC_W'(cfg.data[ORDER_W-1:0]) > CALC_W'(MAX_ORDER)) begin
							order_q <= ORDER_W'(MAX_ORDER);
						end else begin
							order_q <= cfg.data[ORDER_W-1:0];
						end
					end
					CFG_BAND:   bw_q     <= cfg.data[BW_W-1:0];
					CFG_LOWER:  kl_q     <= cfg.data[KL_W-1:0];
					CFG_CUTOFF: cutoff_q <= cfg.data[CUT_W-1:0];
					default: ;
				endcase
			end

			v_s1 <= req.valid && req.ready;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (s2_fire) begin
				v_s2 <= 1'b0;
			end

			if (s2_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_s1    <= req.req_type;
			i_s1       <= req.row_index;
			j_s1       <= req.col_index;
			contrib_s1 <= req.contribution;
			neg_s1     <= req.row_sign_negative ^ req.col_sign_negative;
			raddr_s1   <= req.read_address;
		end
		if (v_s1) begin
			op_s2   <= op_c;
			addr_s2 <= addr_c[ADDR_W-1:0];
			val_s2  <= val_c;
		end
		if (s2_fire) begin
			out_data_q <= res_data_c;
			out_acc_q  <= res_acc_c;
			out_sat_q  <= sat_c && (op_s2 == OP_ACC);
			out_oos_q  <= res_oos_c;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = $signed(out_data_q);
	assign rsp.accumulated  = out_acc_q;
	assign rsp.saturated    = out_sat_q;
	assign rsp.out_of_store = out_oos_q;
endmodule

FILE: hw/rtl/pmsa_checker.sv
// Port-level checks for the packed matrix scatter-accumulate unit, bound to the top level.
// Depends on pmsa_pkg.
module pmsa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [pmsa_pkg::DATA_W-1:0]     read_data,
	input logic                            accumulated,
	input logic                            saturated,
	input logic                            out_of_store
);
	import pmsa_pkg::*;

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
			&& $stable(accumulated) && $stable(saturated) && $stable(out_of_store))
		else $error("stalled result changed");

	// One item in stage one at a time: no request is taken the cycle after one is accepted
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in stage one");

	// A clipped sum comes only from an accumulate and sits at a limit
	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && saturated |-> accumulated && !out_of_store
			&& (read_data == ACC_MAX || read_data == ACC_MIN))
		else $error("saturation flag without a clipped accumulate");

	// An address outside the store writes nothing and returns zero
	a_oos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_of_store |-> !accumulated && !saturated && read_data == '0)
		else $error("out-of-store result carries data");
endmodule

bind packed_matrix_scatter_accumulate_unit pmsa_checker u_pmsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.read_data    (rsp.read_data),
	.accumulated  (rsp.accumulated),
	.saturated    (rsp.saturated),
	.out_of_store (rsp.out_of_store)
);
